[hdl/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies.
`default_nettype none
package rmq_pkg;
  localparam int IN_W    = 18;
  localparam int OUT_W   = 18;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;
  localparam int NLANE   = 4;
  localparam int LANE_W  = 0;

  typedef logic signed [IN_W-1:0]  in_fld_t;
  typedef logic signed [OUT_W-1:0] out_fld_t;

  typedef struct packed {
    logic [NLANE-1:0] neg;
    logic             deg;
  } rmq_flags_t;
endpackage
`default_nettype wire

[hdl/rmq_sel.sv]
// Branch choice, magnitudes, squares and sum of squares (four stages).
// Depends on rmq_pkg.
`default_nettype none
module rmq_sel #(
  parameter int FRAC_BITS = 16,
  parameter int AW        = 22,
  parameter int MW        = 21,
  parameter int SW        = 44
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  rmq_pkg::in_fld_t                    xx,
  input  rmq_pkg::in_fld_t                    xy,
  input  rmq_pkg::in_fld_t                    xz,
  input  rmq_pkg::in_fld_t                    yx,
  input  rmq_pkg::in_fld_t                    yy,
  input  rmq_pkg::in_fld_t                    yz,
  input  rmq_pkg::in_fld_t                    zx,
  input  rmq_pkg::in_fld_t                    zy,
  input  rmq_pkg::in_fld_t                    zz,
  output logic                                out_vld,
  output logic [rmq_pkg::NLANE-1:0][MW-1:0]   mag,
  output rmq_pkg::rmq_flags_t                 flags,
  output logic [SW-1:0]                       sum
);
  import rmq_pkg::*;

  localparam logic signed [AW-1:0] ONE = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [AW-1:0] exx, exy, exz, eyx, eyy, eyz, ezx, ezy, ezz;
  logic signed [AW-1:0] trace, arg_next;
  logic signed [AW-1:0] p_next [NLANE];
  logic signed [AW-1:0] p [NLANE];
  logic                 v1, deg1;

  logic [MW-1:0]     mag2 [NLANE];
  logic [NLANE-1:0]  neg2;
  logic              v2, deg2;

  logic [2*MW-1:0]   sq3 [NLANE];
  logic [MW-1:0]     mag3 [NLANE];
  rmq_flags_t        flags3;
  logic              v3;

  logic [MW-1:0]     mag4 [NLANE];
  rmq_flags_t        flags4;
  logic [SW-1:0]     sum4;
  logic              v4;

  assign exx = AW'(xx);
  assign exy = AW'(xy);
  assign exz = AW'(xz);
  assign eyx = AW'(yx);
  assign eyy = AW'(yy);
  assign eyz = AW'(yz);
  assign ezx = AW'(zx);
  assign ezy = AW'(zy);
  assign ezz = AW'(zz);
  assign trace = exx + eyy + ezz;

  always_comb begin
    priority if (trace > 0) begin
      arg_next  = ONE + trace;
      p_next[0] = arg_next;
      p_next[1] = ezy - eyz;
      p_next[2] = exz - ezx;
      p_next[3] = eyx - exy;
    end else if (exx > eyy && exx > ezz) begin
      arg_next  = ONE + exx - eyy - ezz;
      p_next[0] = ezy - eyz;
      p_next[1] = arg_next;
      p_next[2] = exy + eyx;
      p_next[3] = exz + ezx;
    end else if (eyy > ezz) begin
      arg_next  = ONE + eyy - exx - ezz;
      p_next[0] = exz - ezx;
      p_next[1] = exy + eyx;
      p_next[2] = arg_next;
      p_next[3] = eyz + ezy;
    end else begin
      arg_next  = ONE + ezz - exx - eyy;
      p_next[0] = eyx - exy;
      p_next[1] = exz + ezx;
      p_next[2] = eyz + ezy;
      p_next[3] = arg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NLANE; i++) begin
        p[i]    <= p_next[i];
        mag2[i] <= p[i][AW-1] ? MW'(-p[i]) : MW'(p[i]);
        neg2[i] <= p[i][AW-1];
        sq3[i]  <= (2*MW)'(mag2[i]) * (2*MW)'(mag2[i]);
        mag3[i] <= mag2[i];
        mag4[i] <= mag3[i];
      end
      deg1       <= arg_next[AW-1] || (arg_next == '0);
      deg2       <= deg1;
      flags3.neg <= neg2;
      flags3.deg <= deg2;
      flags4     <= flags3;
      sum4       <= SW'(sq3[0]) + SW'(sq3[1]) + SW'(sq3[2]) + SW'(sq3[3]);
    end
  end

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      mag[i] = mag4[i];
    end
  end
  assign flags   = flags4;
  assign sum     = sum4;
  assign out_vld = v4;
endmodule
`default_nettype wire

[hdl/rmq_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with sideband.
// No package dependency.
`default_nettype none
module rmq_isqrt #(
  parameter int SW  = 44,
  parameter int RW  = 22,
  parameter int SBW = 89
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [SW-1:0]  in_val,
  input  logic [SBW-1:0] in_side,
  output logic           out_vld,
  output logic [RW-1:0]  out_root,
  output logic [SBW-1:0] out_side
);
  logic [SW-1:0]  rem_q  [RW];
  logic [SW-1:0]  res_q  [RW];
  logic           vld_q  [RW];
  logic [SBW-1:0] side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [SW-1:0] BIT = {{(SW-1){1'b0}}, 1'b1} << (2*(RW-1-k));
    logic [SW-1:0]  rem_src, res_src, trial;
    logic           vld_src;
    logic [SBW-1:0] side_src;

    if (k == 0) begin : g_first
      assign rem_src  = in_val;
      assign res_src  = '0;
      assign vld_src  = in_vld;
      assign side_src = in_side;
    end else begin : g_rest
      assign rem_src  = rem_q[k-1];
      assign res_src  = res_q[k-1];
      assign vld_src  = vld_q[k-1];
      assign side_src = side_q[k-1];
    end

    assign trial = res_src + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_src >= trial) begin
          rem_q[k] <= rem_src - trial;
          res_q[k] <= (res_src >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_src;
          res_q[k] <= res_src >> 1;
        end
        side_q[k] <= side_src;
      end
    end
  end

  assign out_vld  = vld_q[RW-1];
  assign out_root = res_q[RW-1][RW-1:0];
  assign out_side = side_q[RW-1];

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld_q[RW-1] |-> (rem_q[RW-1] <= (res_q[RW-1] << 1)))
    else $error("root remainder above 2*root");
endmodule
`default_nettype wire

[hdl/rmq_div.sv]
// Four-lane pipelined restoring divider, one quotient bit per stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div #(
  parameter int QW = 17,
  parameter int RW = 22
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [RW-1:0]                     in_n,
  input  logic [rmq_pkg::NLANE-1:0][RW-1:0] in_rem,
  input  logic [rmq_pkg::NLANE-1:0][QW-1:0] in_low,
  input  rmq_pkg::rmq_flags_t               in_flags,
  output logic                              out_vld,
  output logic [rmq_pkg::NLANE-1:0][QW-1:0] out_q,
  output rmq_pkg::rmq_flags_t               out_flags
);
  import rmq_pkg::*;

  logic                        vld_q   [QW];
  logic [RW-1:0]               n_q     [QW];
  logic [NLANE-1:0][RW-1:0]    rem_q   [QW];
  logic [NLANE-1:0][QW-1:0]    wrd_q   [QW];
  rmq_flags_t                  flags_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     vld_src;
    logic [RW-1:0]            n_src;
    logic [NLANE-1:0][RW-1:0] rem_src, rem_next;
    logic [NLANE-1:0][QW-1:0] wrd_src, wrd_next;
    rmq_flags_t               flags_src;

    if (k == 0) begin : g_first
      assign vld_src   = in_vld;
      assign n_src     = in_n;
      assign rem_src   = in_rem;
      assign wrd_src   = in_low;
      assign flags_src = in_flags;
    end else begin : g_rest
      assign vld_src   = vld_q[k-1];
      assign n_src     = n_q[k-1];
      assign rem_src   = rem_q[k-1];
      assign wrd_src   = wrd_q[k-1];
      assign flags_src = flags_q[k-1];
    end

    always_comb begin
      logic [RW:0] r2;
      logic        ge;
      for (int l = 0; l < NLANE; l++) begin
        r2 = {rem_src[l], wrd_src[l][QW-1]};
        ge = (r2 >= {1'b0, n_src});
        rem_next[l] = ge ? RW'(r2 - {1'b0, n_src}) : r2[RW-1:0];
        wrd_next[l] = {wrd_src[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k]     <= n_src;
        rem_q[k]   <= rem_next;
        wrd_q[k]   <= wrd_next;
        flags_q[k] <= flags_src;
      end
    end
  end

  assign out_vld   = vld_q[QW-1];
  assign out_q     = wrd_q[QW-1];
  assign out_flags = flags_q[QW-1];

  a_rem_lt_n: assert property (@(posedge clk) disable iff (rst)
    vld_q[QW-1] |-> (rem_q[QW-1][0] < n_q[QW-1]) && (rem_q[QW-1][1] < n_q[QW-1]) &&
                    (rem_q[QW-1][2] < n_q[QW-1]) && (rem_q[QW-1][3] < n_q[QW-1]))
    else $error("divider remainder not below divisor");
endmodule
`default_nettype wire

[hdl/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to conjugated unit quaternion, fixed point.
// Depends on rmq_pkg, rmq_sel, rmq_isqrt, rmq_div.
//
//   channel  signals                          direction
//   request  in_valid/in_ready, 9 axis fields  in
//   result   out_valid/out_ready, quat_*, degenerate  out
//
// One request per cycle sustained unless the output stalls; the root and divider
// resolve one bit per stage. Reset clears only the valid bits. A stall freezes
// every stage at once; in_ready is low only while a result waits in the output
// register.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmq_pkg::in_fld_t  x_axis_x,
  input  rmq_pkg::in_fld_t  x_axis_y,
  input  rmq_pkg::in_fld_t  x_axis_z,
  input  rmq_pkg::in_fld_t  y_axis_x,
  input  rmq_pkg::in_fld_t  y_axis_y,
  input  rmq_pkg::in_fld_t  y_axis_z,
  input  rmq_pkg::in_fld_t  z_axis_x,
  input  rmq_pkg::in_fld_t  z_axis_y,
  input  rmq_pkg::in_fld_t  z_axis_z,
  output logic              out_valid,
  input  logic              out_ready,
  output rmq_pkg::out_fld_t quat_w,
  output rmq_pkg::out_fld_t quat_x,
  output rmq_pkg::out_fld_t quat_y,
  output rmq_pkg::out_fld_t quat_z,
  output logic              degenerate
);
  import rmq_pkg::*;

  localparam int AW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
  localparam int MW  = AW - 1;
  localparam int SW  = 2*MW + 2;
  localparam int RW  = MW + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = MW + FRAC_BITS + 1;
  localparam int FW  = $bits(rmq_flags_t);
  localparam int SBW = NLANE*MW + FW;
  localparam int VW  = QW + OUT_W + 1;
  localparam out_fld_t W_ID = (FRAC_BITS >= OUT_W-1) ? OUT_W'(OUT_MAX) : OUT_W'(1 << FRAC_BITS);

  logic en;

  logic                     sel_vld;
  logic [NLANE-1:0][MW-1:0] sel_mag;
  rmq_flags_t               sel_flags;
  logic [SW-1:0]            sel_sum;

  logic                     sq_vld;
  logic [RW-1:0]            sq_root;
  logic [SBW-1:0]           sq_side;
  logic [NLANE-1:0][MW-1:0] sq_mag;
  rmq_flags_t               sq_flags;

  logic [RW-1:0]            n_fix, half;
  logic [NLANE-1:0][RW-1:0] rem_next;
  logic [NLANE-1:0][QW-1:0] low_next;

  logic                     df_vld;
  logic [RW-1:0]            df_n;
  logic [NLANE-1:0][RW-1:0] df_rem;
  logic [NLANE-1:0][QW-1:0] df_low;
  rmq_flags_t               df_flags;

  logic                     dv_vld;
  logic [NLANE-1:0][QW-1:0] dv_q;
  rmq_flags_t               dv_flags;

  out_fld_t                 part [NLANE];

  function automatic out_fld_t sat_out(input logic signed [VW-1:0] v);
    priority if (v > VW'(OUT_MAX)) begin
      return OUT_W'(OUT_MAX);
    end else if (v < VW'(OUT_MIN)) begin
      return OUT_W'(OUT_MIN);
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rmq_sel #(
    .FRAC_BITS(FRAC_BITS), .AW(AW), .MW(MW), .SW(SW)
  ) u_sel (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid),
    .xx(x_axis_x), .xy(x_axis_y), .xz(x_axis_z),
    .yx(y_axis_x), .yy(y_axis_y), .yz(y_axis_z),
    .zx(z_axis_x), .zy(z_axis_y), .zz(z_axis_z),
    .out_vld(sel_vld), .mag(sel_mag), .flags(sel_flags), .sum(sel_sum)
  );

  rmq_isqrt #(
    .SW(SW), .RW(RW), .SBW(SBW)
  ) u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_vld(sel_vld), .in_val(sel_sum),
    .in_side({sel_flags, sel_mag}),
    .out_vld(sq_vld), .out_root(sq_root), .out_side(sq_side)
  );

  assign sq_flags = sq_side[SBW-1 -: FW];
  assign sq_mag   = sq_side[NLANE*MW-1:0];

  // numerator = mag * ONE + n/2; top part seeds the remainder
  assign n_fix = (sq_root == '0) ? RW'(1) : sq_root;
  assign half  = n_fix >> 1;

  always_comb begin
    logic [NW-1:0] num;
    for (int l = 0; l < NLANE; l++) begin
      num = (NW'(sq_mag[l]) << FRAC_BITS) + NW'(half);
      rem_next[l] = RW'(num[NW-1:QW]);
      low_next[l] = num[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      df_vld <= 1'b0;
    end else if (en) begin
      df_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      df_n     <= n_fix;
      df_rem   <= rem_next;
      df_low   <= low_next;
      df_flags <= sq_flags;
    end
  end

  rmq_div #(
    .QW(QW), .RW(RW)
  ) u_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(df_vld), .in_n(df_n),
    .in_rem(df_rem), .in_low(df_low), .in_flags(df_flags),
    .out_vld(dv_vld), .out_q(dv_q), .out_flags(dv_flags)
  );

  // w keeps the sign of its term, x/y/z are conjugated
  always_comb begin
    logic signed [VW-1:0] qv;
    logic                 neg;
    for (int l = 0; l < NLANE; l++) begin
      qv  = $signed(VW'(dv_q[l]));
      neg = (l == LANE_W) ? dv_flags.neg[l] : !dv_flags.neg[l];
      part[l] = sat_out(neg ? -qv : qv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= dv_flags.deg;
      if (dv_flags.deg) begin
        quat_w <= W_ID;
        quat_x <= '0;
        quat_y <= '0;
        quat_z <= '0;
      end else begin
        quat_w <= part[0];
        quat_x <= part[1];
        quat_y <= part[2];
        quat_z <= part[3];
      end
    end
  end

  a_deg_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == W_ID)
    else $error("degenerate result is not identity");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("request stalled with empty output");

  a_root_positive: assert property (@(posedge clk) disable iff (rst)
    df_vld && !df_flags.deg |-> df_n != '0)
    else $error("zero divisor on live request");
endmodule
`default_nettype wire
